// ===== sv/cdms_pkg.sv =====
// ============================================================================
// cdms_pkg
// Shared types, marker constants and helpers for the CDATA marker stripper.
// ============================================================================
package cdms_pkg;

	localparam int BYTE_W  = 8;
	localparam int WIN_N   = 9;
	localparam int OPEN_N  = 9;
	localparam int CLOSE_N = 3;
	localparam int CNT_W   = $clog2(WIN_N + 1);

	typedef logic [BYTE_W-1:0]            byte_t;
	typedef logic [CNT_W-1:0]             cnt_t;
	typedef logic [WIN_N-1:0][BYTE_W-1:0] win_t;

	localparam cnt_t WIN_CNT   = cnt_t'(WIN_N);
	localparam cnt_t OPEN_CNT  = cnt_t'(OPEN_N);
	localparam cnt_t CLOSE_CNT = cnt_t'(CLOSE_N);

	// Entry 0 holds the first character of each marker.
	localparam logic [OPEN_N-1:0][BYTE_W-1:0] OPEN_MARK = {
		8'h5B, 8'h61, 8'h74, 8'h61, 8'h64, 8'h63, 8'h5B, 8'h21, 8'h3C
	};
	localparam logic [CLOSE_N-1:0][BYTE_W-1:0] CLOSE_MARK = {
		8'h3E, 8'h5D, 8'h5D
	};

	typedef struct packed {
		logic opener;
		logic closer;
	} dec_t;

	function automatic byte_t fold_lower(input byte_t b);
		byte_t r;
		r = b;
		if (b inside {[8'h41:8'h5A]}) begin
			r = b + 8'h20;
		end
		return r;
	endfunction

endpackage

// ===== sv/cdms_decide.sv =====
// ============================================================================
// cdms_decide
// Marker detection on the lookahead window: opening marker with letters
// folded to lower case, closing marker exact and only inside a section.
// ============================================================================
module cdms_decide (
	input  cdms_pkg::win_t win,
	input  cdms_pkg::cnt_t cnt,
	input  logic           inside_section,
	output cdms_pkg::dec_t dec
);
	import cdms_pkg::*;

	logic [OPEN_N-1:0]  open_hit;
	logic [CLOSE_N-1:0] close_hit;

	always_comb begin
		for (int i = 0; i < OPEN_N; i++) begin
			open_hit[i] = (fold_lower(win[i]) == OPEN_MARK[i]);
		end
		for (int i = 0; i < CLOSE_N; i++) begin
			close_hit[i] = (win[i] == CLOSE_MARK[i]);
		end
		dec.opener = (cnt >= OPEN_CNT) && (&open_hit);
		dec.closer = inside_section && (cnt >= CLOSE_CNT) && (&close_hit);
	end

endmodule

// ===== sv/cdata_marker_stripper.sv =====
// ============================================================================
// cdata_marker_stripper
// Passes a byte stream through with CDATA opening and closing markers removed.
// ============================================================================
//
// Channel  Dir  Payload                                 Framing
// s_*      in   tdata[7:0] = in_byte                    tlast = in_last
// m_*      out  tdata[7:0] = out_byte, tuser = out_valid tlast = out_last
//
// Within a document one byte is taken per cycle unless the output stalls; the
// marker compare on the nine-byte window sits between the window registers and
// the output register. After the final byte the window drains at one decision
// per cycle while the output can take a byte, then a closing step emits the end
// mark; input is held off until the drain ends.
// Reset clears the window count, the section flag and the output valid.
// A stall on the output holds off input only while the output register is full.
//
module cdata_marker_stripper (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tuser,   // [0] out_valid
	output logic       m_tlast
);
	import cdms_pkg::*;

	win_t  win_q, win_d;
	cnt_t  count_q, count_d;
	logic  inside_q, inside_d;
	logic  drain_q, drain_d;
	logic  pend_v_q, pend_v_d;
	byte_t pend_b_q, pend_b_d;

	win_t  pushed, src;
	cnt_t  src_cnt;
	dec_t  dec;
	logic  can_out, s_acc, decide_en, out_load;
	byte_t out_byte_d;
	logic  out_user_d, out_last_d;

	logic  m_tvalid_q, m_tuser_q, m_tlast_q;
	byte_t m_tdata_q;

	assign can_out  = !m_tvalid_q || m_tready;
	assign s_tready = !drain_q && can_out;
	assign s_acc    = s_tvalid && s_tready;

	always_comb begin
		pushed = win_q;
		for (int i = 0; i < WIN_N; i++) begin
			if (count_q == cnt_t'(i)) begin
				pushed[i] = s_tdata;
			end
		end
		src     = drain_q ? win_q : pushed;
		src_cnt = drain_q ? count_q : count_q + cnt_t'(1);
	end

	cdms_decide u_decide (
		.win            (src),
		.cnt            (src_cnt),
		.inside_section (inside_q),
		.dec            (dec)
	);

	always_comb begin
		win_d      = win_q;
		count_d    = count_q;
		inside_d   = inside_q;
		drain_d    = drain_q;
		pend_v_d   = pend_v_q;
		pend_b_d   = pend_b_q;
		out_load   = 1'b0;
		out_byte_d = src[0];
		out_user_d = 1'b1;
		out_last_d = 1'b0;
		decide_en  = 1'b0;

		if (s_acc) begin
			win_d   = pushed;
			count_d = src_cnt;
			if (s_tlast) begin
				drain_d = 1'b1;
			end else begin
				decide_en = (src_cnt == WIN_CNT);
			end
		end else if (drain_q && can_out) begin
			if (count_q == '0) begin
				out_load   = 1'b1;
				out_byte_d = pend_v_q ? pend_b_q : '0;
				out_user_d = pend_v_q;
				out_last_d = 1'b1;
				drain_d    = 1'b0;
				inside_d   = 1'b0;
				pend_v_d   = 1'b0;
			end else begin
				decide_en = 1'b1;
			end
		end

		if (decide_en) begin
			if (dec.opener) begin
				count_d  = '0;
				inside_d = 1'b1;
			end else if (dec.closer) begin
				win_d    = src >> (CLOSE_N * BYTE_W);
				count_d  = src_cnt - CLOSE_CNT;
				inside_d = 1'b0;
			end else begin
				win_d   = src >> BYTE_W;
				count_d = src_cnt - cnt_t'(1);
				if (drain_q) begin
					// The last emitted byte is held back until the drain ends.
					pend_b_d = src[0];
					pend_v_d = 1'b1;
					if (pend_v_q) begin
						out_load   = 1'b1;
						out_byte_d = pend_b_q;
					end
				end else begin
					out_load = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			inside_q   <= 1'b0;
			drain_q    <= 1'b0;
			pend_v_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			count_q  <= count_d;
			inside_q <= inside_d;
			drain_q  <= drain_d;
			pend_v_q <= pend_v_d;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		win_q    <= win_d;
		pend_b_q <= pend_b_d;
		if (out_load) begin
			m_tdata_q <= out_byte_d;
			m_tuser_q <= out_user_d;
			m_tlast_q <= out_last_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= WIN_CNT)
		else $error("window count above depth");

	a_count_stream: assert property (@(posedge clk) disable iff (!arst_n)
		!drain_q |-> count_q < WIN_CNT)
		else $error("full window outside drain");

	a_pend_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!drain_q |-> !pend_v_q)
		else $error("held byte outside drain");

	a_last_drain: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> drain_q && !s_tready)
		else $error("final byte did not start drain");

	a_empty_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast && m_tdata == '0)
		else $error("empty result without end mark");

endmodule
